/* sv/qyp_pkg.sv */
// Shared types, widths, arctangent table and helper functions for the quaternion angle unit.
package qyp_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int QW           = 16;   // quaternion component
   localparam int PW           = 32;   // product of two components
   localparam int GW           = 34;   // gravity / yaw operands, Q.28
   localparam int HW           = GW - 8; // Q.20 operands for pitch
   localparam int NW           = 2 * HW; // radicand
   localparam int RW           = NW / 2; // root bits, one per sqrt cell
   localparam int MW           = RW + 3; // partial remainder
   localparam int SQ_STEPS     = RW;
   localparam int VW           = 37;   // CORDIC vector
   localparam int AW           = 26;   // angle, degrees * 65536
   localparam int FW           = AW + 2; // angle after pitch fold
   localparam int OW           = 9;
   localparam int SW           = 5;    // CORDIC step index

   localparam logic signed [AW-1:0] ANG_QUARTER = AW'(90 * 65536);
   localparam logic signed [FW-1:0] ANG_HALF    = FW'(180 * 65536);
   localparam logic signed [GW-1:0] ONE_Q28     = GW'(64'd1 << 28);

   typedef struct packed {
      logic signed [GW-1:0] yaw_n;
      logic signed [GW-1:0] yaw_d;
      logic signed [GW-1:0] gy;
      logic signed [GW-1:0] gz;
      logic signed [HW-1:0] gx20;
   } side_type;

   typedef struct packed {
      logic [NW-1:0] n_rest;
      logic [MW-1:0] rem;
      logic [RW-1:0] root;
      side_type      side;
   } sq_type;

   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [AW-1:0] ang;
      logic                 zero;
      logic                 tag;
   } vec_type;

   // atan(2^-i) in degrees * 65536, rounded
   function automatic logic signed [AW-1:0] atan_tab(input logic [SW-1:0] idx);
      logic signed [AW-1:0] v;
      case (idx)
         5'd0:    v = AW'(2949120);
         5'd1:    v = AW'(1740967);
         5'd2:    v = AW'(919879);
         5'd3:    v = AW'(466945);
         5'd4:    v = AW'(234379);
         5'd5:    v = AW'(117304);
         5'd6:    v = AW'(58666);
         5'd7:    v = AW'(29335);
         5'd8:    v = AW'(14668);
         5'd9:    v = AW'(7334);
         5'd10:   v = AW'(3667);
         5'd11:   v = AW'(1833);
         5'd12:   v = AW'(917);
         5'd13:   v = AW'(458);
         5'd14:   v = AW'(229);
         5'd15:   v = AW'(115);
         5'd16:   v = AW'(57);
         5'd17:   v = AW'(29);
         5'd18:   v = AW'(14);
         5'd19:   v = AW'(7);
         5'd20:   v = AW'(4);
         5'd21:   v = AW'(2);
         5'd22:   v = AW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

   // quarter-turn so that x >= 0 before the CORDIC steps
   function automatic vec_type pre_rotate(input logic signed [VW-1:0] y,
                                          input logic signed [VW-1:0] x,
                                          input logic tag);
      vec_type v;
      v.zero = (x == '0) && (y == '0);
      v.tag  = tag;
      v.x    = x;
      v.y    = y;
      v.ang  = '0;
      if (x < 0) begin
         if (y >= 0) begin
            v.x   = y;
            v.y   = -x;
            v.ang = ANG_QUARTER;
         end else begin
            v.x   = -y;
            v.y   = x;
            v.ang = -ANG_QUARTER;
         end
      end
      return v;
   endfunction

   // floor to whole degrees, offset by 180, clamp to 0..360
   function automatic logic [OW-1:0] to_degrees(input logic signed [FW-1:0] a);
      logic signed [FW-16:0] d;
      d = (FW-15)'(a >>> 16) + (FW-15)'(180);
      if (d < 0)
         return '0;
      else if (d > 360)
         return OW'(360);
      else
         return d[OW-1:0];
   endfunction

endpackage

/* sv/qyp_sqrt_cell.sv */
// One cell of the pipelined square root: settles one root bit per stage.
module qyp_sqrt_cell (
   input  logic           clock,
   input  logic           enable,
   input  qyp_pkg::sq_type d_in,
   output qyp_pkg::sq_type d_out
);

   qyp_pkg::sq_type             d_ff;
   qyp_pkg::sq_type             d_in_next;
   logic [qyp_pkg::MW-1:0]      rem_sh;
   logic [qyp_pkg::MW-1:0]      trial;

   always_comb begin
      rem_sh    = {d_in.rem[qyp_pkg::MW-4:0], d_in.n_rest[qyp_pkg::NW-1 -: 2]};
      trial     = qyp_pkg::MW'({d_in.root, 2'b01});
      d_in_next = d_in;
      d_in_next.n_rest = {d_in.n_rest[qyp_pkg::NW-3:0], 2'b00};
      if (rem_sh >= trial) begin
         d_in_next.rem  = rem_sh - trial;
         d_in_next.root = {d_in.root[qyp_pkg::RW-2:0], 1'b1};
      end else begin
         d_in_next.rem  = rem_sh;
         d_in_next.root = {d_in.root[qyp_pkg::RW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         d_ff <= d_in_next;
      end
   end

   assign d_out = d_ff;

endmodule

/* sv/qyp_cordic_cell.sv */
// One vectoring CORDIC cell: a single micro-rotation toward the x axis.
module qyp_cordic_cell (
   input  logic                    clock,
   input  logic                    enable,
   input  logic [qyp_pkg::SW-1:0]  step,
   input  qyp_pkg::vec_type        v_in,
   output qyp_pkg::vec_type        v_out
);

   qyp_pkg::vec_type            v_ff;
   qyp_pkg::vec_type            v_next;
   logic signed [qyp_pkg::VW-1:0] dx;
   logic signed [qyp_pkg::VW-1:0] dy;

   always_comb begin
      dx     = v_in.y >>> step;
      dy     = v_in.x >>> step;
      v_next = v_in;
      if (v_in.y >= 0) begin
         v_next.x   = v_in.x + dx;
         v_next.y   = v_in.y - dy;
         v_next.ang = v_in.ang + qyp_pkg::atan_tab(step);
      end else begin
         v_next.x   = v_in.x - dx;
         v_next.y   = v_in.y + dy;
         v_next.ang = v_in.ang - qyp_pkg::atan_tab(step);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         v_ff <= v_next;
      end
   end

   assign v_out = v_ff;

endmodule

/* sv/quaternion_to_yaw_pitch_roll_unit.sv */
// Quaternion to yaw / pitch / roll conversion, fully pipelined top level.
//
// Takes one Q2.14 quaternion per transfer and returns yaw, pitch and roll as whole
// degrees plus 180 (0..360). The unit accepts one transfer per clock unless
// rsp_stall has backed the pipeline up to its input. Four stages form the
// products, gravity terms and pitch radicand, 26 square-root cells give one root bit
// each, one stage pre-rotates, one CORDIC cell per step runs the three atan2 vectors
// side by side, and a last stage folds pitch and clamps into the output register.
// Every stage has its own valid bit and moves whenever the stage after it is empty
// or moving, so bubbles collapse and rsp_stall only holds back what it must.
module quaternion_to_yaw_pitch_roll_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [qyp_pkg::QW-1:0] req_quat_w,
   input  logic signed [qyp_pkg::QW-1:0] req_quat_x,
   input  logic signed [qyp_pkg::QW-1:0] req_quat_y,
   input  logic signed [qyp_pkg::QW-1:0] req_quat_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [qyp_pkg::OW-1:0]        rsp_yaw_deg,
   output logic [qyp_pkg::OW-1:0]        rsp_pitch_deg,
   output logic [qyp_pkg::OW-1:0]        rsp_roll_deg
);

   localparam int SQ    = qyp_pkg::SQ_STEPS;
   localparam int CS    = qyp_pkg::CORDIC_STEPS;
   localparam int ST_SQ = 3;             // radicand register
   localparam int ST_PR = 4 + SQ;        // pre-rotate
   localparam int ST_FN = 5 + SQ + CS;   // output register
   localparam int NSTG  = ST_FN + 1;

   // stage valids and advance chain
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] adv;

   always_comb begin
      adv[NSTG-1] = !vld_ff[NSTG-1] || !rsp_stall;
      for (int i = NSTG - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < NSTG; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = vld_ff[NSTG-1];

   // stage 0: component products, exact Q.28
   logic signed [qyp_pkg::PW-1:0] ww_ff, xx_ff, yy_ff, zz_ff, xz_ff;
   logic signed [qyp_pkg::PW-1:0] wy_ff, wx_ff, yz_ff, xy_ff, wz_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         ww_ff <= req_quat_w * req_quat_w;
         xx_ff <= req_quat_x * req_quat_x;
         yy_ff <= req_quat_y * req_quat_y;
         zz_ff <= req_quat_z * req_quat_z;
         xz_ff <= req_quat_x * req_quat_z;
         wy_ff <= req_quat_w * req_quat_y;
         wx_ff <= req_quat_w * req_quat_x;
         yz_ff <= req_quat_y * req_quat_z;
         xy_ff <= req_quat_x * req_quat_y;
         wz_ff <= req_quat_w * req_quat_z;
      end
   end

   // stage 1: gravity vector and yaw operands
   qyp_pkg::side_type side1_ff;
   qyp_pkg::side_type side1_in;

   always_comb begin
      side1_in.gy    = (qyp_pkg::GW'(wx_ff) + qyp_pkg::GW'(yz_ff)) <<< 1;
      side1_in.gz    = qyp_pkg::GW'(ww_ff) - qyp_pkg::GW'(xx_ff)
                     - qyp_pkg::GW'(yy_ff) + qyp_pkg::GW'(zz_ff);
      side1_in.yaw_n = (qyp_pkg::GW'(xy_ff) - qyp_pkg::GW'(wz_ff)) <<< 1;
      side1_in.yaw_d = ((qyp_pkg::GW'(ww_ff) + qyp_pkg::GW'(xx_ff)) <<< 1)
                     - qyp_pkg::ONE_Q28;
      // gx kept only as its Q.20 floor
      side1_in.gx20  = qyp_pkg::HW'(((qyp_pkg::GW'(xz_ff) - qyp_pkg::GW'(wy_ff)) <<< 1)
                                    >>> 8);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         side1_ff <= side1_in;
      end
   end

   // stage 2: squares of gy, gz in Q.20
   qyp_pkg::side_type             side2_ff;
   logic signed [qyp_pkg::NW-1:0] sqy_ff, sqz_ff;
   logic signed [qyp_pkg::HW-1:0] gy20, gz20;

   assign gy20 = qyp_pkg::HW'(side1_ff.gy >>> 8);
   assign gz20 = qyp_pkg::HW'(side1_ff.gz >>> 8);

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         side2_ff <= side1_ff;
         sqy_ff   <= gy20 * gy20;
         sqz_ff   <= gz20 * gz20;
      end
   end

   // stage 3: radicand into the square-root chain
   qyp_pkg::sq_type sq [0:SQ];

   always_ff @(posedge clock) begin
      if (adv[ST_SQ]) begin
         sq[0].n_rest <= qyp_pkg::NW'(sqy_ff + sqz_ff);
         sq[0].rem    <= '0;
         sq[0].root   <= '0;
         sq[0].side   <= side2_ff;
      end
   end

   for (genvar k = 0; k < SQ; k++) begin : g_sqrt
      qyp_sqrt_cell u_cell (
         .clock  (clock),
         .enable (adv[ST_SQ+1+k]),
         .d_in   (sq[k]),
         .d_out  (sq[k+1])
      );
   end

   // pre-rotation of the three atan2 vectors
   qyp_pkg::vec_type yaw_v   [0:CS];
   qyp_pkg::vec_type pitch_v [0:CS];
   qyp_pkg::vec_type roll_v  [0:CS];
   qyp_pkg::side_type sd;

   assign sd = sq[SQ].side;

   always_ff @(posedge clock) begin
      if (adv[ST_PR]) begin
         yaw_v[0]   <= qyp_pkg::pre_rotate(qyp_pkg::VW'(sd.yaw_n),
                                           qyp_pkg::VW'(sd.yaw_d), 1'b0);
         pitch_v[0] <= qyp_pkg::pre_rotate(qyp_pkg::VW'(sd.gx20),
                                           qyp_pkg::VW'({1'b0, sq[SQ].root}),
                                           sd.gz[qyp_pkg::GW-1]);
         roll_v[0]  <= qyp_pkg::pre_rotate(qyp_pkg::VW'(sd.gy),
                                           qyp_pkg::VW'(sd.gz), 1'b0);
      end
   end

   for (genvar k = 0; k < CS; k++) begin : g_cordic
      qyp_cordic_cell u_yaw (
         .clock  (clock),
         .enable (adv[ST_PR+1+k]),
         .step   (qyp_pkg::SW'(k)),
         .v_in   (yaw_v[k]),
         .v_out  (yaw_v[k+1])
      );
      qyp_cordic_cell u_pitch (
         .clock  (clock),
         .enable (adv[ST_PR+1+k]),
         .step   (qyp_pkg::SW'(k)),
         .v_in   (pitch_v[k]),
         .v_out  (pitch_v[k+1])
      );
      qyp_cordic_cell u_roll (
         .clock  (clock),
         .enable (adv[ST_PR+1+k]),
         .step   (qyp_pkg::SW'(k)),
         .v_in   (roll_v[k]),
         .v_out  (roll_v[k+1])
      );
   end

   // final stage: zero-vector override, pitch fold, degrees and clamp
   logic signed [qyp_pkg::FW-1:0] yaw_a, pitch_a, pitch_f, roll_a;
   logic [qyp_pkg::OW-1:0]        yaw_ff, pitch_ff, roll_ff;

   always_comb begin
      yaw_a   = yaw_v[CS].zero   ? '0 : qyp_pkg::FW'(yaw_v[CS].ang);
      pitch_a = pitch_v[CS].zero ? '0 : qyp_pkg::FW'(pitch_v[CS].ang);
      roll_a  = roll_v[CS].zero  ? '0 : qyp_pkg::FW'(roll_v[CS].ang);
      pitch_f = pitch_a;
      // gravity pointing down: mirror pitch about +-90
      if (pitch_v[CS].tag) begin
         if (pitch_a > 0)
            pitch_f = qyp_pkg::ANG_HALF - pitch_a;
         else
            pitch_f = -qyp_pkg::ANG_HALF - pitch_a;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_FN]) begin
         yaw_ff   <= qyp_pkg::to_degrees(yaw_a);
         pitch_ff <= qyp_pkg::to_degrees(pitch_f);
         roll_ff  <= qyp_pkg::to_degrees(roll_a);
      end
   end

   assign rsp_yaw_deg   = yaw_ff;
   assign rsp_pitch_deg = pitch_ff;
   assign rsp_roll_deg  = roll_ff;

endmodule
